// ===== hdl/sfvs_pkg.sv =====
// shared types, constants and bit-search helpers for the scan floor visit scheduler
// no dependencies; imported by the controller, the datapath and the top level
package sfvs_pkg;

   localparam int NUM_FLOORS   = 64;
   localparam int TIME_BITS    = 32;

   localparam int REQ_BITS     = 64;
   localparam int FLOOR_BITS   = 6;
   localparam int TICK_BITS    = 16;
   localparam int ARRIVAL_BITS = 32;
   localparam int DELTA_BITS   = FLOOR_BITS + TICK_BITS;
   localparam int SUM_BITS     = ((TIME_BITS > DELTA_BITS) ? TIME_BITS : DELTA_BITS) + 1;
   localparam int CSR_IDX_BITS = 1;
   localparam int CSR_DATA_BITS = TICK_BITS;

   localparam logic [REQ_BITS-1:0]   FLOOR_MASK = {REQ_BITS{1'b1}} >> (REQ_BITS - NUM_FLOORS);
   localparam logic [FLOOR_BITS-1:0] TOP_FLOOR  = FLOOR_BITS'(NUM_FLOORS - 1);
   localparam logic [TICK_BITS-1:0]  TICKS_RESET = TICK_BITS'(1);

   localparam logic [CSR_IDX_BITS-1:0] REG_TICKS_PER_FLOOR = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_START_FLOOR     = 1'd1;

   typedef struct packed {
      logic [REQ_BITS-1:0] floor_requests;
      logic                go_down_first;
   } req_type;

   typedef struct packed {
      logic [FLOOR_BITS-1:0]   visited_floor;
      logic [ARRIVAL_BITS-1:0] arrival_time;
      logic                    last_visit;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic issue;
   } cmd_type;

   typedef struct packed {
      logic pending;
      logic pipe_empty;
   } stat_type;

   function automatic logic [REQ_BITS-1:0] lowest_onehot(input logic [REQ_BITS-1:0] x);
      return x & (~x + REQ_BITS'(1));
   endfunction

   function automatic logic [REQ_BITS-1:0] highest_onehot(input logic [REQ_BITS-1:0] x);
      logic [REQ_BITS-1:0] rev;
      logic [REQ_BITS-1:0] oh;
      logic [REQ_BITS-1:0] res;
      for (int i = 0; i < REQ_BITS; i++) begin
         rev[i] = x[REQ_BITS-1-i];
      end
      oh = lowest_onehot(rev);
      for (int i = 0; i < REQ_BITS; i++) begin
         res[i] = oh[REQ_BITS-1-i];
      end
      return res;
   endfunction

   function automatic logic [FLOOR_BITS-1:0] onehot_index(input logic [REQ_BITS-1:0] oh);
      logic [FLOOR_BITS-1:0] idx;
      idx = '0;
      for (int i = 0; i < REQ_BITS; i++) begin
         if (oh[i]) begin
            idx = idx | FLOOR_BITS'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ===== hdl/sfvs_ctrl.sv =====
// sequencer for the scan floor visit scheduler: idle, issue visits, drain pipeline
// depends on sfvs_pkg
module sfvs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   output sfvs_pkg::cmd_type  cmd,
   input  sfvs_pkg::stat_type stat
);
   import sfvs_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd.load  = 1'b0;
      cmd.issue = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            // leave once no floor is left pending: the last pick has gone out (or nothing was requested)
            if (!stat.pending) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (stat.pipe_empty) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== hdl/sfvs_dpath.sv =====
// datapath: sweep masks, floor picker, distance, travel-time multiply, saturating clock
// depends on sfvs_pkg
module sfvs_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  sfvs_pkg::cmd_type                   cmd,
   output sfvs_pkg::stat_type                  stat,
   input  sfvs_pkg::req_type                   req_data,
   input  logic                                csr_we,
   input  logic [sfvs_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [sfvs_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output logic                                rsp_valid,
   output sfvs_pkg::rsp_type                   rsp_data
);
   import sfvs_pkg::*;

   logic [TICK_BITS-1:0]  ticks_ff;
   logic [FLOOR_BITS-1:0] cur_floor_ff;
   logic [TIME_BITS-1:0]  elapsed_ff;
   logic [TIME_BITS-1:0]  elapsed_in;
   logic [REQ_BITS-1:0]   first_ff;
   logic [REQ_BITS-1:0]   second_ff;
   logic                  first_dn_ff;

   logic                  s1_valid_ff;
   logic [FLOOR_BITS-1:0] s1_floor_ff;
   logic [FLOOR_BITS-1:0] s1_dist_ff;
   logic                  s1_last_ff;
   logic                  s2_valid_ff;
   logic [FLOOR_BITS-1:0] s2_floor_ff;
   logic [DELTA_BITS-1:0] s2_delta_ff;
   logic                  s2_last_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic [REQ_BITS-1:0]   cur_bit;
   logic [REQ_BITS-1:0]   req_m;
   logic [REQ_BITS-1:0]   below;
   logic [REQ_BITS-1:0]   above;
   logic                  first_any;
   logic [REQ_BITS-1:0]   src;
   logic                  dir_dn;
   logic [REQ_BITS-1:0]   pick_oh;
   logic [FLOOR_BITS-1:0] pick_floor;
   logic [REQ_BITS-1:0]   rest;
   logic                  pick_last;
   logic                  do_pick;
   logic [FLOOR_BITS-1:0] pick_dist;
   logic [FLOOR_BITS-1:0] start_sat;
   logic [SUM_BITS-1:0]   sum;

   // split the request into the floors above and below the car
   always_comb begin
      cur_bit = REQ_BITS'(1) << cur_floor_ff;
      req_m   = req_data.floor_requests & FLOOR_MASK & ~cur_bit;
      below   = req_m & (cur_bit - REQ_BITS'(1));
      above   = req_m & ~below;
   end

   // one visit per cycle: lowest bit going up, highest bit going down
   always_comb begin
      first_any  = |first_ff;
      src        = first_any ? first_ff : second_ff;
      dir_dn     = first_any ? first_dn_ff : !first_dn_ff;
      pick_oh    = dir_dn ? highest_onehot(src) : lowest_onehot(src);
      pick_floor = onehot_index(pick_oh);
      rest       = src ^ pick_oh;
      pick_last  = first_any ? ((rest == '0) && (second_ff == '0)) : (rest == '0);
      do_pick    = cmd.issue && (first_any || (|second_ff));
      pick_dist  = (pick_floor > cur_floor_ff) ? (pick_floor - cur_floor_ff)
                                               : (cur_floor_ff - pick_floor);
      start_sat  = ({1'b0, csr_wdata[FLOOR_BITS-1:0]} > {1'b0, TOP_FLOOR}) ?
                   TOP_FLOOR : csr_wdata[FLOOR_BITS-1:0];
   end

   always_comb begin
      sum        = SUM_BITS'(elapsed_ff) + SUM_BITS'(s2_delta_ff);
      elapsed_in = (|(sum >> TIME_BITS)) ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff     <= TICKS_RESET;
         cur_floor_ff <= '0;
         elapsed_ff   <= '0;
         first_ff     <= '0;
         second_ff    <= '0;
         first_dn_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we && (csr_index == REG_TICKS_PER_FLOOR)) begin
            ticks_ff <= csr_wdata[TICK_BITS-1:0];
         end

         if (csr_we && (csr_index == REG_START_FLOOR)) begin
            cur_floor_ff <= start_sat;
         end else if (do_pick) begin
            cur_floor_ff <= pick_floor;
         end

         if (csr_we && (csr_index == REG_START_FLOOR)) begin
            elapsed_ff <= '0;
         end else if (s2_valid_ff) begin
            elapsed_ff <= elapsed_in;
         end

         if (cmd.load) begin
            first_ff    <= req_data.go_down_first ? below : above;
            second_ff   <= req_data.go_down_first ? above : below;
            first_dn_ff <= req_data.go_down_first;
         end else if (do_pick) begin
            if (first_any) begin
               first_ff <= rest;
            end else begin
               second_ff <= rest;
            end
         end

         s1_valid_ff  <= do_pick;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (do_pick) begin
         s1_floor_ff <= pick_floor;
         s1_dist_ff  <= pick_dist;
         s1_last_ff  <= pick_last;
      end
      if (s1_valid_ff) begin
         s2_floor_ff <= s1_floor_ff;
         s2_delta_ff <= DELTA_BITS'(s1_dist_ff) * DELTA_BITS'(ticks_ff);
         s2_last_ff  <= s1_last_ff;
      end
      if (s2_valid_ff) begin
         rsp_ff.visited_floor <= s2_floor_ff;
         rsp_ff.arrival_time  <= ARRIVAL_BITS'(elapsed_in);
         rsp_ff.last_visit    <= s2_last_ff;
      end
   end

   assign stat.pending    = (|first_ff) || (|second_ff);
   assign stat.pipe_empty = !s1_valid_ff && !s2_valid_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

endmodule

// ===== hdl/scan_floor_visit_scheduler_unit.sv =====
// scan floor visit scheduler, top level: controller plus datapath
// the first visit is picked in the scan state and passes the s1, s2 and response registers; then one visit per cycle
// an item keeps busy high while its visits are picked and the pipeline drains, one bit picked
//   per cycle by the priority encoder; an empty request frees the block after the scan and drain states
// results are strobed for one cycle on rsp_valid; the receiver cannot stall
// synchronous active-high reset: ticks_per_floor = 1, floor 0, elapsed time 0, idle
module scan_floor_visit_scheduler_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  sfvs_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   output sfvs_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [sfvs_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [sfvs_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import sfvs_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   sfvs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   sfvs_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // a visit that is not the last one means the item is still in flight
   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last_visit) |-> busy)
      else $error("non-final visit while idle");

   // the last visit of an item is never directly followed by another visit
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last_visit) |=> !rsp_valid)
      else $error("visit right after a final visit");

   // results only come out of an item in progress
   a_rsp_in_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("visit without an item in progress");

   // every visited floor lies within the building
   a_floor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_data.visited_floor} <= {1'b0, TOP_FLOOR}))
      else $error("visited floor out of range");

endmodule
